FILE: hw/rtl/mcte_pkg.sv
// Shared widths, codes, constants and sequencer states of the MIDI clock tempo estimator.
`timescale 1ns / 1ps

package mcte_pkg;

   // Field widths of the request, response and control channels
   localparam int REQ_TYPE_W = 2;
   localparam int TIME_W     = 32;
   localparam int TEMPO_W    = 17;
   localparam int FILL_W     = 3;
   localparam int SPACING_W  = 12;

   // Request codes; the fourth code is ignored
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_POLL = 2'd0,
      REQ_DROP = 2'd1,
      REQ_COLD = 2'd2
   } mcte_req_code_type;

   // Fixed arithmetic constants
   localparam logic [TIME_W-1:0]    FIRST_AGE_MAX = 32'd250;
   localparam logic [SPACING_W-1:0] SPACING_RESET = 12'd250;
   // 60000 ms/min * 256 (Q8) / 24 PPQN
   localparam logic [19:0]          Q8_SCALE      = 20'd640000;
   localparam logic [TEMPO_W-1:0]   Q8_MIN        = 17'd5120;
   localparam logic [TEMPO_W-1:0]   Q8_MAX        = 17'd128000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_LAST,
      ST_BASE,
      ST_T0,
      ST_RDK,
      ST_LDK,
      ST_RDL,
      ST_LDL,
      ST_MSQ,
      ST_MXY,
      ST_ACC,
      ST_CHK,
      ST_BIGM,
      ST_BIGA,
      ST_RANGE,
      ST_DIV,
      ST_FIN,
      ST_DONE
   } mcte_state_type;

endpackage

FILE: hw/rtl/mcte_if.sv
// Valid/ready channel interfaces for requests, responses and the spacing register.
`timescale 1ns / 1ps

interface mcte_req_if;
   logic                            valid;
   logic                            ready;
   logic [mcte_pkg::REQ_TYPE_W-1:0] req_type;
   logic [mcte_pkg::TIME_W-1:0]     now_ms;
   logic [mcte_pkg::TIME_W-1:0]     clock_count;
   logic [mcte_pkg::TIME_W-1:0]     edge_ms;
   logic                            clocks_fresh;

   modport source (output valid, req_type, now_ms, clock_count, edge_ms, clocks_fresh,
                   input ready);
   modport sink   (input valid, req_type, now_ms, clock_count, edge_ms, clocks_fresh,
                   output ready);
endinterface

interface mcte_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mcte_pkg::TEMPO_W-1:0]  tempo_bpm_q8;
   logic [mcte_pkg::FILL_W-1:0]   window_fill;
   logic                          sample_taken;

   modport source (output valid, tempo_bpm_q8, window_fill, sample_taken, input ready);
   modport sink   (input valid, tempo_bpm_q8, window_fill, sample_taken, output ready);
endinterface

interface mcte_csr_if;
   logic                           valid;
   logic                           ready;
   logic [mcte_pkg::SPACING_W-1:0] sample_spacing_ms;

   modport source (output valid, sample_spacing_ms, input ready);
   modport sink   (input valid, sample_spacing_ms, output ready);
endinterface

FILE: hw/rtl/mcte_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mcte_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 5
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/midi_clock_tempo_estimator.sv
// Top level of the MIDI clock tempo estimator: window store, fit sequencer and divider.
`timescale 1ns / 1ps

// Each request polls the clock state or drops the sample window. Polls keep a ring of up
// to WINDOW_SAMPLES (clock count, edge time) samples in a small RAM and, once two or more
// are held, fit an exact least-squares slope over all sample pairs, convert it to BPM in
// unsigned Q9.8 and keep it when it lies from 20 to 500 BPM. One request is worked at a
// time and every request returns one response. The time that a fitting poll takes is set
// by the pair walk, which reads one sample per pair through the RAM read port and runs
// two products through the one shared 32x32 multiplier, and by the 17-step restoring
// divider for the quotient. A finished response sits in an output register, so the next
// request is accepted while it waits. The window RAM holds no reset value and gets no
// clearing pass: the fill count guards every read. The spacing register is written
// through its own channel and is always ready.

module midi_clock_tempo_estimator #(
   parameter int WINDOW_SAMPLES = 5
) (
   input  logic       clock,
   input  logic       reset,
   mcte_req_if.sink   req_ch,
   mcte_rsp_if.source rsp_ch,
   mcte_csr_if.sink   csr_ch
);

   // ------------------------------------------------------------------------------------
   // Sizes
   // ------------------------------------------------------------------------------------
   localparam int TIME_W    = mcte_pkg::TIME_W;
   localparam int TEMPO_W   = mcte_pkg::TEMPO_W;
   localparam int FILL_W    = mcte_pkg::FILL_W;
   localparam int SPACING_W = mcte_pkg::SPACING_W;
   localparam int PTR_W     = $clog2(WINDOW_SAMPLES);
   localparam int BASE_W    = PTR_W + 1;
   localparam int CNT_W     = $clog2(WINDOW_SAMPLES + 1);
   localparam int PAIRS     = WINDOW_SAMPLES * (WINDOW_SAMPLES - 1) / 2;
   // Sum of up to PAIRS 64-bit products
   localparam int ACC_W     = 64 + $clog2(PAIRS + 1);
   localparam int NUM_W     = ACC_W + 1;
   localparam int LIMBS     = (ACC_W + 31) / 32;
   localparam int LIMB_IW   = $clog2(LIMBS);
   localparam int PAD_W     = LIMBS * 32;
   localparam int BIG_W     = PAD_W + 20;
   localparam int BITC_W    = $clog2(TEMPO_W);
   localparam int ENTRY_W   = 2 * TIME_W;

   // ------------------------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------------------------
   mcte_pkg::mcte_state_type state_ff, state_in;

   // Request held for the duration of its work
   logic [mcte_pkg::REQ_TYPE_W-1:0] type_ff, type_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [TIME_W-1:0]   clk_ff, clk_in;
   logic [TIME_W-1:0]   edge_ff, edge_in;
   logic                fresh_ff, fresh_in;

   // Architectural state
   logic [SPACING_W-1:0] spacing_ff, spacing_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [TEMPO_W-1:0]   tempo_ff, tempo_in;
   logic                 taken_ff, taken_in;

   // Fit walk
   logic [TIME_W-1:0]   t0_ff, t0_in;
   logic [TIME_W-1:0]   c0_ff, c0_in;
   logic [TIME_W-1:0]   xk_ff, xk_in;
   logic [TIME_W-1:0]   yk_ff, yk_in;
   logic [PTR_W-1:0]    kptr_ff, kptr_in;
   logic [PTR_W-1:0]    lptr_ff, lptr_in;
   logic [CNT_W-1:0]    kcnt_ff, kcnt_in;
   logic [CNT_W-1:0]    lcnt_ff, lcnt_in;
   logic [TIME_W-1:0]   ax_ff, ax_in;
   logic [TIME_W-1:0]   ay_ff, ay_in;
   logic                neg_ff, neg_in;
   logic [63:0]         mul_p_ff;
   logic [ACC_W-1:0]    den_ff, den_in;
   logic [NUM_W-1:0]    num_ff, num_in;

   // Scale and divide; big_ff turns into the remainder during division
   logic [BIG_W-1:0]    big_ff, big_in;
   logic [BIG_W-1:0]    dsh_ff, dsh_in;
   logic [LIMB_IW-1:0]  j_ff, j_in;
   logic [TEMPO_W-1:0]  q_ff, q_in;
   logic [BITC_W-1:0]   bit_ff, bit_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TEMPO_W-1:0]  out_tempo_ff, out_tempo_in;
   logic [FILL_W-1:0]   out_fill_ff, out_fill_in;
   logic                out_taken_ff, out_taken_in;

   // ------------------------------------------------------------------------------------
   // Window RAM: {clock count, edge time} per entry
   // ------------------------------------------------------------------------------------
   logic               ram_we;
   logic [PTR_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [TIME_W-1:0]  rd_count;
   logic [TIME_W-1:0]  rd_time;

   mcte_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW_SAMPLES)
   ) u_window (
      .clock (clock),
      .we    (ram_we),
      .waddr (head_ff),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign ram_wdata = {clk_ff, edge_ff};
   assign rd_count  = ram_rdata[ENTRY_W-1:TIME_W];
   assign rd_time   = ram_rdata[TIME_W-1:0];

   // ------------------------------------------------------------------------------------
   // Helpers
   // ------------------------------------------------------------------------------------
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(WINDOW_SAMPLES - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   logic [PTR_W-1:0]  head_prev;
   logic [BASE_W-1:0] base_sum;
   logic [PTR_W-1:0]  base_ptr;
   logic              take_first;
   logic              take_next;
   logic              take_now;
   logic              fit_due;
   logic              num_pos;
   logic              rsp_load;
   logic              accept;
   logic [TIME_W-1:0] mul_a;
   logic [TIME_W-1:0] mul_b;
   logic [TIME_W-1:0] xl;
   logic [TIME_W-1:0] yl;
   logic [TIME_W:0]   dx;
   logic [TIME_W:0]   dy;
   logic [PAD_W-1:0]  num_pad;
   logic [BIG_W-1:0]  prod_shift;

   // Newest sample sits just behind the write head
   assign head_prev = (head_ff == '0) ? PTR_W'(WINDOW_SAMPLES - 1) : head_ff - PTR_W'(1);

   // Oldest sample: head - fill, wrapped once
   assign base_sum = BASE_W'(head_ff) + BASE_W'(WINDOW_SAMPLES) - BASE_W'(fill_ff);
   assign base_ptr = (base_sum >= BASE_W'(WINDOW_SAMPLES))
                     ? PTR_W'(base_sum - BASE_W'(WINDOW_SAMPLES))
                     : PTR_W'(base_sum);

   // Empty window: take the sample when the clock edge is recent enough
   assign take_first = (now_ff - edge_ff) <= mcte_pkg::FIRST_AGE_MAX;
   // Otherwise: count moved and edge far enough past the newest sample
   assign take_next  = (clk_ff != rd_count) &&
                       ((edge_ff - rd_time) >= TIME_W'(spacing_ff));

   // Offsets of the pair's second sample from the oldest one
   assign xl = rd_time - t0_ff;
   assign yl = rd_count - c0_ff;
   assign dx = {1'b0, xk_ff} - {1'b0, xl};
   assign dy = {yk_ff[TIME_W-1], yk_ff} - {yl[TIME_W-1], yl};

   assign num_pos    = !num_ff[NUM_W-1] && (num_ff != '0);
   assign num_pad    = PAD_W'(num_ff[ACC_W-1:0]);
   assign prod_shift = BIG_W'(mul_p_ff) << {j_ff, 5'b0};

   assign accept = req_ch.valid && req_ch.ready;

   // ------------------------------------------------------------------------------------
   // Shared multiplier, one product per cycle
   // ------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
   end

   // ------------------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcte_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = mcte_pkg::ST_DECIDE;
            end
         end
         mcte_pkg::ST_DECIDE: begin
            if (type_ff == mcte_pkg::REQ_POLL && fresh_ff && fill_ff != '0) begin
               state_in = mcte_pkg::ST_LAST;
            end else begin
               state_in = mcte_pkg::ST_DONE;
            end
         end
         mcte_pkg::ST_LAST: begin
            state_in = fit_due ? mcte_pkg::ST_BASE : mcte_pkg::ST_DONE;
         end
         mcte_pkg::ST_BASE: state_in = mcte_pkg::ST_T0;
         mcte_pkg::ST_T0:   state_in = mcte_pkg::ST_RDK;
         mcte_pkg::ST_RDK:  state_in = mcte_pkg::ST_LDK;
         mcte_pkg::ST_LDK:  state_in = mcte_pkg::ST_RDL;
         mcte_pkg::ST_RDL:  state_in = mcte_pkg::ST_LDL;
         mcte_pkg::ST_LDL:  state_in = mcte_pkg::ST_MSQ;
         mcte_pkg::ST_MSQ:  state_in = mcte_pkg::ST_MXY;
         mcte_pkg::ST_MXY:  state_in = mcte_pkg::ST_ACC;
         mcte_pkg::ST_ACC: begin
            if ((lcnt_ff + CNT_W'(1)) < fill_ff) begin
               state_in = mcte_pkg::ST_RDL;
            end else if ((kcnt_ff + CNT_W'(2)) < fill_ff) begin
               state_in = mcte_pkg::ST_RDK;
            end else begin
               state_in = mcte_pkg::ST_CHK;
            end
         end
         mcte_pkg::ST_CHK: begin
            if (den_ff == '0 || !num_pos) begin
               state_in = mcte_pkg::ST_DONE;
            end else begin
               state_in = mcte_pkg::ST_BIGM;
            end
         end
         mcte_pkg::ST_BIGM: state_in = mcte_pkg::ST_BIGA;
         mcte_pkg::ST_BIGA: begin
            if (j_ff == LIMB_IW'(LIMBS - 1)) begin
               state_in = mcte_pkg::ST_RANGE;
            end else begin
               state_in = mcte_pkg::ST_BIGM;
            end
         end
         mcte_pkg::ST_RANGE: begin
            // Quotient of 2^17 or more lies beyond the top of the band
            if (big_ff >= (BIG_W'(den_ff) << TEMPO_W)) begin
               state_in = mcte_pkg::ST_DONE;
            end else begin
               state_in = mcte_pkg::ST_DIV;
            end
         end
         mcte_pkg::ST_DIV: begin
            if (bit_ff == '0) begin
               state_in = mcte_pkg::ST_FIN;
            end
         end
         mcte_pkg::ST_FIN:  state_in = mcte_pkg::ST_DONE;
         mcte_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = mcte_pkg::ST_IDLE;
            end
         end
         default: state_in = mcte_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------------------
   // Sequencer outputs: RAM port, multiplier operands, handshakes
   // ------------------------------------------------------------------------------------
   always_comb begin
      ram_raddr = '0;
      take_now  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         mcte_pkg::ST_DECIDE: begin
            ram_raddr = head_prev;
            if (type_ff == mcte_pkg::REQ_POLL && fresh_ff && fill_ff == '0) begin
               take_now = take_first;
            end
         end
         mcte_pkg::ST_LAST:  take_now  = take_next;
         mcte_pkg::ST_BASE:  ram_raddr = base_ptr;
         mcte_pkg::ST_RDK:   ram_raddr = kptr_ff;
         mcte_pkg::ST_RDL:   ram_raddr = lptr_ff;
         mcte_pkg::ST_MSQ: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         mcte_pkg::ST_MXY: begin
            mul_a = ax_ff;
            mul_b = ay_ff;
         end
         mcte_pkg::ST_BIGM: begin
            mul_a = num_pad[j_ff*32 +: 32];
            mul_b = TIME_W'(mcte_pkg::Q8_SCALE);
         end
         mcte_pkg::ST_DONE:  rsp_load = !rsp_valid_ff || rsp_ch.ready;
         default: begin
         end
      endcase
   end

   // Fit whenever two or more samples are held after this poll
   assign fit_due = (fill_ff >= CNT_W'(2)) || take_now;
   assign ram_we  = take_now;

   // ------------------------------------------------------------------------------------
   // Datapath next values
   // ------------------------------------------------------------------------------------
   always_comb begin
      type_in      = type_ff;
      now_in       = now_ff;
      clk_in       = clk_ff;
      edge_in      = edge_ff;
      fresh_in     = fresh_ff;
      spacing_in   = spacing_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      tempo_in     = tempo_ff;
      taken_in     = taken_ff;
      t0_in        = t0_ff;
      c0_in        = c0_ff;
      xk_in        = xk_ff;
      yk_in        = yk_ff;
      kptr_in      = kptr_ff;
      lptr_in      = lptr_ff;
      kcnt_in      = kcnt_ff;
      lcnt_in      = lcnt_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      big_in       = big_ff;
      dsh_in       = dsh_ff;
      j_in         = j_ff;
      q_in         = q_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff;
      out_tempo_in = out_tempo_ff;
      out_fill_in  = out_fill_ff;
      out_taken_in = out_taken_ff;

      // Register writes are independent of the sequencer
      if (csr_ch.valid) begin
         spacing_in = csr_ch.sample_spacing_ms;
      end

      // Drop the response once taken; a new load below overrides
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Append the sample at the write head
      if (take_now) begin
         head_in  = ptr_inc(head_ff);
         fill_in  = (fill_ff == CNT_W'(WINDOW_SAMPLES)) ? fill_ff : fill_ff + CNT_W'(1);
         taken_in = 1'b1;
      end

      unique case (state_ff)
         mcte_pkg::ST_IDLE: begin
            if (accept) begin
               type_in  = req_ch.req_type;
               now_in   = req_ch.now_ms;
               clk_in   = req_ch.clock_count;
               edge_in  = req_ch.edge_ms;
               fresh_in = req_ch.clocks_fresh;
               taken_in = 1'b0;
            end
         end
         mcte_pkg::ST_DECIDE: begin
            unique case (type_ff)
               mcte_pkg::REQ_DROP: begin
                  fill_in = '0;
                  head_in = '0;
               end
               mcte_pkg::REQ_COLD: begin
                  fill_in  = '0;
                  head_in  = '0;
                  tempo_in = '0;
               end
               mcte_pkg::REQ_POLL: begin
                  // Clock dropout empties the window
                  if (!fresh_ff) begin
                     fill_in = '0;
                     head_in = '0;
                  end
               end
               default: begin
               end
            endcase
         end
         mcte_pkg::ST_T0: begin
            t0_in   = rd_time;
            c0_in   = rd_count;
            kptr_in = base_ptr;
            kcnt_in = '0;
            den_in  = '0;
            num_in  = '0;
         end
         mcte_pkg::ST_LDK: begin
            xk_in   = rd_time - t0_ff;
            yk_in   = rd_count - c0_ff;
            lptr_in = ptr_inc(kptr_ff);
            lcnt_in = kcnt_ff + CNT_W'(1);
         end
         mcte_pkg::ST_LDL: begin
            ax_in  = dx[TIME_W] ? TIME_W'(-dx) : dx[TIME_W-1:0];
            ay_in  = dy[TIME_W] ? TIME_W'(-dy) : dy[TIME_W-1:0];
            neg_in = dx[TIME_W] ^ dy[TIME_W];
         end
         mcte_pkg::ST_MXY: begin
            den_in = den_ff + ACC_W'(mul_p_ff);
         end
         mcte_pkg::ST_ACC: begin
            num_in = neg_ff ? num_ff - NUM_W'(mul_p_ff) : num_ff + NUM_W'(mul_p_ff);
            if ((lcnt_ff + CNT_W'(1)) < fill_ff) begin
               lptr_in = ptr_inc(lptr_ff);
               lcnt_in = lcnt_ff + CNT_W'(1);
            end else begin
               kptr_in = ptr_inc(kptr_ff);
               kcnt_in = kcnt_ff + CNT_W'(1);
            end
         end
         mcte_pkg::ST_CHK: begin
            big_in = '0;
            j_in   = '0;
         end
         mcte_pkg::ST_BIGA: begin
            big_in = big_ff + prod_shift;
            j_in   = j_ff + LIMB_IW'(1);
         end
         mcte_pkg::ST_RANGE: begin
            dsh_in = BIG_W'(den_ff) << (TEMPO_W - 1);
            q_in   = '0;
            bit_in = BITC_W'(TEMPO_W - 1);
         end
         mcte_pkg::ST_DIV: begin
            // Restoring division, one quotient bit per cycle
            if (big_ff >= dsh_ff) begin
               big_in = big_ff - dsh_ff;
               q_in   = {q_ff[TEMPO_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[TEMPO_W-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            bit_in = bit_ff - BITC_W'(1);
         end
         mcte_pkg::ST_FIN: begin
            // Keep the estimate only inside the band; the top edge must be exact
            if (q_ff >= mcte_pkg::Q8_MIN &&
                (q_ff < mcte_pkg::Q8_MAX || (q_ff == mcte_pkg::Q8_MAX && big_ff == '0))) begin
               tempo_in = q_ff;
            end
         end
         mcte_pkg::ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               out_tempo_in = tempo_ff;
               out_fill_in  = FILL_W'(fill_ff);
               out_taken_in = taken_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcte_pkg::ST_IDLE;
         spacing_ff   <= mcte_pkg::SPACING_RESET;
         fill_ff      <= '0;
         head_ff      <= '0;
         tempo_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         spacing_ff   <= spacing_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         tempo_ff     <= tempo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      now_ff       <= now_in;
      clk_ff       <= clk_in;
      edge_ff      <= edge_in;
      fresh_ff     <= fresh_in;
      taken_ff     <= taken_in;
      t0_ff        <= t0_in;
      c0_ff        <= c0_in;
      xk_ff        <= xk_in;
      yk_ff        <= yk_in;
      kptr_ff      <= kptr_in;
      lptr_ff      <= lptr_in;
      kcnt_ff      <= kcnt_in;
      lcnt_ff      <= lcnt_in;
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      neg_ff       <= neg_in;
      den_ff       <= den_in;
      num_ff       <= num_in;
      big_ff       <= big_in;
      dsh_ff       <= dsh_in;
      j_ff         <= j_in;
      q_ff         <= q_in;
      bit_ff       <= bit_in;
      out_tempo_ff <= out_tempo_in;
      out_fill_ff  <= out_fill_in;
      out_taken_ff <= out_taken_in;
   end

   // ------------------------------------------------------------------------------------
   // Ports
   // ------------------------------------------------------------------------------------
   assign req_ch.ready        = (state_ff == mcte_pkg::ST_IDLE);
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.tempo_bpm_q8 = out_tempo_ff;
   assign rsp_ch.window_fill  = out_fill_ff;
   assign rsp_ch.sample_taken = out_taken_ff;

endmodule
